/* rtl/core/bps_pkg.sv */
package bps_pkg;

  // Sizing of the bin store and of the count fields.
  localparam int BIN_COUNT  = 64;
  localparam int COUNT_BITS = 16;

  localparam int BIN_AW  = (BIN_COUNT > 1) ? $clog2(BIN_COUNT) : 1;
  localparam int CNT_W   = COUNT_BITS;
  localparam int WGT_W   = 2 * CNT_W;
  localparam int SUM_W   = WGT_W + BIN_AW;
  localparam int DRAW_W  = 48;
  localparam int CFG_W   = 32;
  localparam int FRAC    = 16;
  localparam int PROP_W  = 63;
  localparam int MUL_A_W = (SUM_W > DRAW_W) ? SUM_W : DRAW_W;
  localparam int PROD_W  = MUL_A_W + CFG_W;
  localparam int QUO_W   = PROD_W + FRAC;
  localparam int MUL_CW  = $clog2(CFG_W);
  localparam int DIV_CW  = $clog2(QUO_W);

  // Reset values of the configuration registers (1.0 in UQ16.16).
  localparam logic [CFG_W-1:0] RATE_RST = CFG_W'(65536);
  localparam logic [CFG_W-1:0] BW_RST   = CFG_W'(65536);

  // Configuration register indexes.
  typedef enum logic [1:0] {
    CFG_KIND,
    CFG_RATE,
    CFG_BIN_WIDTH
  } cfg_idx_e;

  // Input beat.
  typedef struct packed {
    logic        mode;
    logic [5:0]  bin;
    logic [15:0] reactant_count;
    logic [15:0] catalyst_count;
    logic [15:0] product_count;
    logic [47:0] draw;
  } in_t;

  // Result beat.
  typedef struct packed {
    logic [62:0] propensity;
    logic [5:0]  chosen_bin;
    logic [15:0] reactant_after;
    logic [15:0] product_after;
    logic        overrun;
  } out_t;

  // One row of the bin store.
  typedef struct packed {
    logic [CNT_W-1:0] react;
    logic [CNT_W-1:0] cat;
    logic [CNT_W-1:0] prod;
    logic [WGT_W-1:0] wgt;
  } row_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DISPATCH,
    ST_SET_WR,
    ST_FIRE_MUL,
    ST_FIRE_DIV,
    ST_WALK_RD,
    ST_WALK_CMP,
    ST_PROP_GO,
    ST_PROP_MUL,
    ST_PROP_DIV,
    ST_FINISH
  } state_e;

  typedef enum logic {
    MUL_DRAW,
    MUL_SUM
  } mul_sel_e;

  typedef enum logic [1:0] {
    DIV_PROD,
    DIV_PROD_FRAC,
    DIV_DRAW_FRAC
  } div_sel_e;

  typedef enum logic [1:0] {
    PROP_PROD,
    PROP_QUO,
    PROP_MAX
  } prop_src_e;

  typedef enum logic {
    RD_SET,
    RD_WALK
  } rd_sel_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic      cap_in;
    logic      rd_en;
    rd_sel_e   rd_sel;
    logic      set_wr;
    logic      mul_start;
    mul_sel_e  mul_sel;
    logic      div_start;
    div_sel_e  div_sel;
    logic      d_load;
    logic      d_max;
    logic      walk_next;
    logic      fire_wr;
    logic      prop_ld;
    prop_src_e prop_src;
    logic      load_out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mode;
    logic kind;
    logic rate_zero;
    logic bw_zero;
    logic mul_done;
    logic div_done;
    logic pass;
    logic last;
  } sts_t;

  // Saturate a wide fixed point value to the propensity width.
  function automatic logic [PROP_W-1:0] sat_prop(input logic [QUO_W-1:0] v);
    logic [PROP_W-1:0] r;
    if (v[QUO_W-1:PROP_W] != '0) begin
      r = '1;
    end else begin
      r = v[PROP_W-1:0];
    end
    return r;
  endfunction

endpackage

/* rtl/core/bps_mul.sv */
module bps_mul
  import bps_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic [MUL_A_W-1:0] a_i,
  input  logic [CFG_W-1:0]   b_i,
  output logic [PROD_W-1:0]  prod_o,
  output logic               done_o
);

  logic [PROD_W-1:0] acc_q, mcand_q;
  logic [CFG_W-1:0]  mplr_q;
  logic [MUL_CW-1:0] cnt_q;
  logic              busy_q, done_q;

  // Step counter: one multiplier bit per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == MUL_CW'(CFG_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // Shift and add.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q   <= '0;
      mcand_q <= PROD_W'(a_i);
      mplr_q  <= b_i;
    end else if (busy_q) begin
      if (mplr_q[0]) begin
        acc_q <= acc_q + mcand_q;
      end
      mcand_q <= {mcand_q[PROD_W-2:0], 1'b0};
      mplr_q  <= {1'b0, mplr_q[CFG_W-1:1]};
    end
  end

  assign prod_o = acc_q;
  assign done_o = done_q;

endmodule

/* rtl/core/bps_div.sv */
module bps_div
  import bps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start_i,
  input  logic [QUO_W-1:0] dividend_i,
  input  logic [CFG_W-1:0] divisor_i,
  output logic [QUO_W-1:0] quo_o,
  output logic             done_o
);

  logic [QUO_W-1:0]  quo_q;
  logic [CFG_W-1:0]  rem_q, dsr_q, rem_d;
  logic [CFG_W:0]    trial, diff;
  logic              ge;
  logic [DIV_CW-1:0] cnt_q;
  logic              busy_q, done_q;

  // One restoring step: bring down the next dividend bit.
  always_comb begin
    trial = {rem_q, quo_q[QUO_W-1]};
    diff  = trial - {1'b0, dsr_q};
    ge    = (trial >= {1'b0, dsr_q});
    rem_d = ge ? diff[CFG_W-1:0] : trial[CFG_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else if (busy_q) begin
      cnt_q <= cnt_q + 1'b1;
      if (cnt_q == DIV_CW'(QUO_W - 1)) begin
        busy_q <= 1'b0;
        done_q <= 1'b1;
      end
    end else begin
      done_q <= 1'b0;
    end
  end

  // The quotient register shifts the dividend out and quotient bits in.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= dividend_i;
      rem_q <= '0;
      dsr_q <= divisor_i;
    end else if (busy_q) begin
      quo_q <= {quo_q[QUO_W-2:0], ge};
      rem_q <= rem_d;
    end
  end

  assign quo_o  = quo_q;
  assign done_o = done_q;

endmodule

/* rtl/core/bps_dp.sv */
module bps_dp
  import bps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  in_t              in_data_i,
  input  cmd_t             cmd_i,
  output sts_t             sts_o,
  output out_t             out_data_o
);

  logic              kind_q;
  logic [CFG_W-1:0]  rate_q, bw_q;
  in_t               in_q;
  logic [SUM_W-1:0]  ws_q;
  logic [QUO_W-1:0]  d_q;
  logic [BIN_AW-1:0] idx_q, set_addr, rd_addr;
  logic [BIN_COUNT-1:0] vld_q;
  row_t              mem [BIN_COUNT];
  row_t              rd_q, row, new_row, fire_row;
  logic              rd_vld_q;
  logic              bin_ok;
  logic [WGT_W+FRAC-1:0] w16;
  logic [BIN_AW-1:0] chosen_q;
  logic              over_q;
  logic [CNT_W-1:0]  r_after_q, p_after_q;
  logic [PROP_W-1:0] prop_q;
  out_t              out_q;

  logic [MUL_A_W-1:0] mul_a;
  logic [CFG_W-1:0]   mul_b, dsr;
  logic [PROD_W-1:0]  prod;
  logic               mul_done, div_done;
  logic [QUO_W-1:0]   dividend, quo;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= 1'b0;
      rate_q <= RATE_RST;
      bw_q   <= BW_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_KIND:      kind_q <= cfg_wdata_i[0];
        CFG_RATE:      rate_q <= cfg_wdata_i;
        CFG_BIN_WIDTH: bw_q   <= cfg_wdata_i;
        default:       ;
      endcase
    end
  end

  // New row for a set beat.
  always_comb begin
    set_addr      = BIN_AW'(in_q.bin);
    bin_ok        = (32'(in_q.bin) < 32'(BIN_COUNT));
    new_row.react = CNT_W'(in_q.reactant_count);
    new_row.cat   = CNT_W'(in_q.catalyst_count);
    new_row.prod  = CNT_W'(in_q.product_count);
    new_row.wgt   = {{CNT_W{1'b0}}, new_row.react} * {{CNT_W{1'b0}}, new_row.cat};
    rd_addr       = (cmd_i.rd_sel == RD_SET) ? set_addr : idx_q;
  end

  // Rows never written read as zero.
  assign row = rd_vld_q ? rd_q : '0;
  assign w16 = {row.wgt, {FRAC{1'b0}}};

  // Updated row of the chosen bin on a fire beat.
  always_comb begin
    fire_row       = row;
    fire_row.react = (row.react == '0) ? row.react : row.react - 1'b1;
    fire_row.prod  = (&row.prod) ? row.prod : row.prod + 1'b1;
  end

  // Bin store.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_q <= mem[rd_addr];
    end
    if (cmd_i.set_wr && bin_ok) begin
      mem[set_addr] <= new_row;
    end else if (cmd_i.fire_wr) begin
      mem[idx_q] <= fire_row;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
      ws_q     <= '0;
    end else begin
      if (cmd_i.rd_en) begin
        rd_vld_q <= vld_q[rd_addr];
      end
      if (cmd_i.set_wr && bin_ok) begin
        vld_q[set_addr] <= 1'b1;
        ws_q <= ws_q - SUM_W'(row.wgt) + SUM_W'(new_row.wgt);
      end else if (cmd_i.fire_wr) begin
        vld_q[idx_q] <= 1'b1;
      end
    end
  end

  // Shared multiplier and divider operand selection.
  always_comb begin
    mul_a = (cmd_i.mul_sel == MUL_SUM) ? MUL_A_W'(ws_q) : MUL_A_W'(in_q.draw);
    mul_b = (cmd_i.mul_sel == MUL_SUM) ? rate_q : bw_q;
    case (cmd_i.div_sel)
      DIV_PROD:      dividend = QUO_W'(prod);
      DIV_PROD_FRAC: dividend = {prod, {FRAC{1'b0}}};
      DIV_DRAW_FRAC: dividend = QUO_W'({in_q.draw, {FRAC{1'b0}}});
      default:       dividend = QUO_W'(prod);
    endcase
    dsr = (cmd_i.div_sel == DIV_PROD_FRAC) ? bw_q : rate_q;
  end

  bps_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (cmd_i.mul_start),
    .a_i     (mul_a),
    .b_i     (mul_b),
    .prod_o  (prod),
    .done_o  (mul_done)
  );

  bps_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (dividend),
    .divisor_i  (dsr),
    .quo_o      (quo),
    .done_o     (div_done)
  );

  // Beat capture, walk state and result fields.
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap_in) begin
      in_q  <= in_data_i;
      idx_q <= '0;
    end else if (cmd_i.walk_next) begin
      idx_q <= idx_q + 1'b1;
    end
    if (cmd_i.d_max) begin
      d_q <= '1;
    end else if (cmd_i.d_load) begin
      d_q <= quo;
    end else if (cmd_i.walk_next) begin
      d_q <= d_q - QUO_W'(w16);
    end
    if (cmd_i.set_wr) begin
      chosen_q  <= '0;
      over_q    <= 1'b0;
      r_after_q <= bin_ok ? new_row.react : '0;
      p_after_q <= bin_ok ? new_row.prod : '0;
    end else if (cmd_i.fire_wr) begin
      chosen_q  <= idx_q;
      over_q    <= (d_q > QUO_W'(w16));
      r_after_q <= fire_row.react;
      p_after_q <= fire_row.prod;
    end
    if (cmd_i.prop_ld) begin
      case (cmd_i.prop_src)
        PROP_PROD: prop_q <= sat_prop(QUO_W'(prod));
        PROP_QUO:  prop_q <= sat_prop(quo);
        PROP_MAX:  prop_q <= '1;
        default:   prop_q <= '1;
      endcase
    end
    if (cmd_i.load_out) begin
      out_q.propensity     <= prop_q;
      out_q.chosen_bin     <= 6'(chosen_q);
      out_q.reactant_after <= 16'(r_after_q);
      out_q.product_after  <= 16'(p_after_q);
      out_q.overrun        <= over_q;
    end
  end

  // Status back to the controller.
  always_comb begin
    sts_o.mode      = in_q.mode;
    sts_o.kind      = kind_q;
    sts_o.rate_zero = (rate_q == '0);
    sts_o.bw_zero   = (bw_q == '0);
    sts_o.mul_done  = mul_done;
    sts_o.div_done  = div_done;
    sts_o.pass      = (d_q > QUO_W'(w16));
    sts_o.last      = (idx_q == BIN_AW'(BIN_COUNT - 1));
  end

  assign out_data_o = out_q;

endmodule

/* rtl/core/bps_ctrl.sv */
module bps_ctrl
  import bps_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_stall_o,
  output logic out_valid_o,
  input  logic out_stall_i,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;

  // State and result valid registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    out_valid_d = out_valid_q && out_stall_i;
    in_stall_o  = 1'b1;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.cap_in = 1'b1;
          state_d      = ST_DISPATCH;
        end
      end
      ST_DISPATCH: begin
        if (!sts_i.mode) begin
          cmd_o.rd_en  = 1'b1;
          cmd_o.rd_sel = RD_SET;
          state_d      = ST_SET_WR;
        end else if (sts_i.rate_zero) begin
          cmd_o.d_max = 1'b1;
          state_d     = ST_WALK_RD;
        end else if (!sts_i.kind) begin
          cmd_o.mul_start = 1'b1;
          cmd_o.mul_sel   = MUL_DRAW;
          state_d         = ST_FIRE_MUL;
        end else begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_DRAW_FRAC;
          state_d         = ST_FIRE_DIV;
        end
      end
      ST_SET_WR: begin
        cmd_o.set_wr = 1'b1;
        state_d      = ST_PROP_GO;
      end
      ST_FIRE_MUL: begin
        if (sts_i.mul_done) begin
          cmd_o.div_start = 1'b1;
          cmd_o.div_sel   = DIV_PROD;
          state_d         = ST_FIRE_DIV;
        end
      end
      ST_FIRE_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.d_load = 1'b1;
          state_d      = ST_WALK_RD;
        end
      end
      ST_WALK_RD: begin
        cmd_o.rd_en  = 1'b1;
        cmd_o.rd_sel = RD_WALK;
        state_d      = ST_WALK_CMP;
      end
      ST_WALK_CMP: begin
        // Pass the bin while the draw is above its weight; the last bin stops the walk.
        if (sts_i.pass && !sts_i.last) begin
          cmd_o.walk_next = 1'b1;
          state_d         = ST_WALK_RD;
        end else begin
          cmd_o.fire_wr = 1'b1;
          state_d       = ST_PROP_GO;
        end
      end
      ST_PROP_GO: begin
        cmd_o.mul_start = 1'b1;
        cmd_o.mul_sel   = MUL_SUM;
        state_d         = ST_PROP_MUL;
      end
      ST_PROP_MUL: begin
        if (sts_i.mul_done) begin
          if (sts_i.kind) begin
            cmd_o.prop_ld  = 1'b1;
            cmd_o.prop_src = PROP_PROD;
            state_d        = ST_FINISH;
          end else if (sts_i.bw_zero) begin
            cmd_o.prop_ld  = 1'b1;
            cmd_o.prop_src = PROP_MAX;
            state_d        = ST_FINISH;
          end else begin
            cmd_o.div_start = 1'b1;
            cmd_o.div_sel   = DIV_PROD_FRAC;
            state_d         = ST_PROP_DIV;
          end
        end
      end
      ST_PROP_DIV: begin
        if (sts_i.div_done) begin
          cmd_o.prop_ld  = 1'b1;
          cmd_o.prop_src = PROP_QUO;
          state_d        = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // Load the result once the output register is free or being taken.
        if (!out_valid_q || !out_stall_i) begin
          cmd_o.load_out = 1'b1;
          out_valid_d    = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  assign out_valid_o = out_valid_q;

endmodule

/* rtl/core/binned_propensity_selector.sv */
// Weighted bin selector: one beat at a time. Its work is done by the shared shift-add
// multiplier (one multiplier bit per step), the shared restoring divider (one quotient bit
// per step) and the walk over the bin store, which reads a row and compares it before it
// moves on to the next. A set beat runs one multiply and, in catalytic mode with a nonzero
// bin width, one divide; a fire beat adds a multiply and divide to scale the draw
// (catalytic) or a divide alone (sticky), both skipped when the rate is zero, and then the
// walk. A new beat is taken while the last result still waits on the output. The store
// needs no clearing after reset: rows never written read as zero.
module binned_propensity_selector
  import bps_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_wdata_i,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  in_t              in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output out_t             out_data_o
);

  cmd_t cmd;
  sts_t sts;

  bps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  bps_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_data_o  (out_data_o)
  );

endmodule

/* rtl/core/bps_checker.sv */
module bps_checker
  import bps_pkg::*;
(
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input out_t             out_data_o
);

  // A stalled result beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("result beat changed while stalled");

  // One beat at a time: the input stalls right after a beat is taken.
  a_one_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while a beat is in flight");

  // An overrun always reports the last bin.
  a_overrun_bin: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overrun |-> out_data_o.chosen_bin == 6'(BIN_COUNT - 1))
    else $error("overrun without the last bin");

  // A new result never appears in the cycle right after a beat is taken.
  a_no_early: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && !out_valid_o |=> !out_valid_o)
    else $error("result appeared too early");

endmodule

bind binned_propensity_selector bps_checker u_bps_checker (.*);
